// File: rtl/bfpa_pkg.sv
package bfpa_pkg;

  localparam int MAX_PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF      = 16;

  localparam int KIND_W       = 2;
  localparam int IDX_FIELD_W  = 4;
  localparam int SIZE_FIELD_W = 16;
  localparam int OWNER_W      = 8;
  localparam int ACTIVE_W     = 5;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
  localparam logic                REG_ACTIVE   = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } pkt_ctl_t;

endpackage

// File: rtl/bfpa_cell.sv
module bfpa_cell
  import bfpa_pkg::*;
#(
  parameter int CELL_ID = 0,
  parameter int IDX_W   = 4,
  parameter int CNT_W   = 5,
  parameter int SIZE_W  = SIZE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [CNT_W-1:0]       cnt_i,
  input  logic                   wb_en_i,
  input  logic [IDX_W-1:0]       wb_idx_i,
  input  logic [SIZE_W-1:0]      wb_free_i,
  input  logic [OWNER_W-1:0]     wb_owner_i,
  input  pkt_ctl_t               ctl_i,
  input  logic [IDX_FIELD_W-1:0] idx_i,
  input  logic [SIZE_W-1:0]      size_i,
  input  logic [OWNER_W-1:0]     tag_i,
  input  logic                   found_i,
  input  logic [IDX_W-1:0]       best_i,
  input  logic [IDX_FIELD_W-1:0] res_idx_i,
  input  logic [SIZE_W-1:0]      res_free_i,
  input  logic [SIZE_W-1:0]      res_cap_i,
  input  logic [OWNER_W-1:0]     res_owner_i,
  input  logic                   res_alloc_i,
  output pkt_ctl_t               ctl_o,
  output logic [IDX_FIELD_W-1:0] idx_o,
  output logic [SIZE_W-1:0]      size_o,
  output logic [OWNER_W-1:0]     tag_o,
  output logic                   found_o,
  output logic [IDX_W-1:0]       best_o,
  output logic [IDX_FIELD_W-1:0] res_idx_o,
  output logic [SIZE_W-1:0]      res_free_o,
  output logic [SIZE_W-1:0]      res_cap_o,
  output logic [OWNER_W-1:0]     res_owner_o,
  output logic                   res_alloc_o
);

  localparam logic [31:0]      ID32   = 32'(CELL_ID);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

  logic [SIZE_W-1:0]      cap_r, cap_nxt;
  logic [SIZE_W-1:0]      free_r, free_nxt;
  logic [OWNER_W-1:0]     own_r, own_nxt;

  pkt_ctl_t               ctl_r;
  logic [IDX_FIELD_W-1:0] idx_r;
  logic [SIZE_W-1:0]      size_r;
  logic [OWNER_W-1:0]     tag_r;
  logic                   found_r, found_nxt;
  logic [IDX_W-1:0]       best_r, best_nxt;
  logic [IDX_FIELD_W-1:0] res_idx_r, res_idx_nxt;
  logic [SIZE_W-1:0]      res_free_r, res_free_nxt;
  logic [SIZE_W-1:0]      res_cap_r, res_cap_nxt;
  logic [OWNER_W-1:0]     res_owner_r, res_owner_nxt;
  logic                   res_alloc_r, res_alloc_nxt;

  logic                   hit;
  logic                   in_scan;
  logic                   fits;
  logic [SIZE_W-1:0]      left;

  assign hit     = (32'(idx_i) == ID32);
  assign in_scan = (ID32 < 32'(cnt_i));
  assign fits    = (free_r >= size_i);
  assign left    = free_r - size_i;

  always_comb begin
    cap_nxt       = cap_r;
    free_nxt      = free_r;
    own_nxt       = own_r;
    found_nxt     = found_i;
    best_nxt      = best_i;
    res_idx_nxt   = res_idx_i;
    res_free_nxt  = res_free_i;
    res_cap_nxt   = res_cap_i;
    res_owner_nxt = res_owner_i;
    res_alloc_nxt = res_alloc_i;
    if (ctl_i.valid) begin
      case (ctl_i.kind)
        KIND_LOAD: begin
          if (hit) begin
            cap_nxt       = size_i;
            free_nxt      = size_i;
            res_free_nxt  = size_i;
            res_cap_nxt   = size_i;
            res_owner_nxt = own_r;
            res_alloc_nxt = 1'b0;
          end
        end
        KIND_READ: begin
          if (hit) begin
            res_free_nxt  = free_r;
            res_cap_nxt   = cap_r;
            res_owner_nxt = own_r;
            res_alloc_nxt = (free_r != cap_r);
          end
        end
        KIND_ALLOC: begin
          if (in_scan && fits && (!found_i || (left <= res_free_i))) begin
            found_nxt     = 1'b1;
            best_nxt      = MY_IDX;
            res_idx_nxt   = ID32[IDX_FIELD_W-1:0];
            res_free_nxt  = left;
            res_cap_nxt   = cap_r;
            res_owner_nxt = tag_i;
            res_alloc_nxt = (left != cap_r);
          end
        end
        default: begin
        end
      endcase
    end
    if (wb_en_i && (wb_idx_i == MY_IDX)) begin
      free_nxt = wb_free_i;
      own_nxt  = wb_owner_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
      own_r <= '0;
    end else begin
      ctl_r <= ctl_i;
      own_r <= own_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cap_r       <= cap_nxt;
    free_r      <= free_nxt;
    idx_r       <= idx_i;
    size_r      <= size_i;
    tag_r       <= tag_i;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    res_idx_r   <= res_idx_nxt;
    res_free_r  <= res_free_nxt;
    res_cap_r   <= res_cap_nxt;
    res_owner_r <= res_owner_nxt;
    res_alloc_r <= res_alloc_nxt;
  end

  assign ctl_o       = ctl_r;
  assign idx_o       = idx_r;
  assign size_o      = size_r;
  assign tag_o       = tag_r;
  assign found_o     = found_r;
  assign best_o      = best_r;
  assign res_idx_o   = res_idx_r;
  assign res_free_o  = res_free_r;
  assign res_cap_o   = res_cap_r;
  assign res_owner_o = res_owner_r;
  assign res_alloc_o = res_alloc_r;

endmodule

// File: rtl/best_fit_partition_allocator.sv
// Path: a request walks the row of partition cells, one cell per cycle, then passes
// through the final result register into the output register, which drives out_valid.
// Flow: a new request is accepted only after the previous result has moved into the
// output register, so requests never overlap in the cell row; a result may wait at the output.
// Reset: synchronous active-low rst_n clears control, owner tags and sets
// active_partitions to 16; capacities and free space hold until loaded.
module best_fit_partition_allocator
  import bfpa_pkg::*;
#(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS      = SIZE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic [IDX_FIELD_W-1:0]  in_partition_index,
  input  logic [SIZE_FIELD_W-1:0] in_size_value,
  input  logic [OWNER_W-1:0]      in_owner_tag,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_fit_found,
  output logic [IDX_FIELD_W-1:0]  out_chosen_index,
  output logic [SIZE_FIELD_W-1:0] out_free_left,
  output logic [SIZE_FIELD_W-1:0] out_capacity_out,
  output logic [OWNER_W-1:0]      out_owner_out,
  output logic                    out_is_allocated,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [ADDR_W-1:0]       cfg_paddr,
  input  logic [DATA_W-1:0]       cfg_pwdata,
  output logic [DATA_W-1:0]       cfg_prdata,
  output logic                    cfg_pready
);

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
  localparam int NST   = MAX_PARTITIONS + 1;

  pkt_ctl_t               ctl_w       [NST];
  logic [IDX_FIELD_W-1:0] idx_w       [NST];
  logic [SIZE_BITS-1:0]   size_w      [NST];
  logic [OWNER_W-1:0]     tag_w       [NST];
  logic                   found_w     [NST];
  logic [IDX_W-1:0]       best_w      [NST];
  logic [IDX_FIELD_W-1:0] res_idx_w   [NST];
  logic [SIZE_BITS-1:0]   res_free_w  [NST];
  logic [SIZE_BITS-1:0]   res_cap_w   [NST];
  logic [OWNER_W-1:0]     res_owner_w [NST];
  logic                   res_alloc_w [NST];

  logic [ACTIVE_W-1:0]    act_r, act_nxt;
  logic [CNT_W-1:0]       cnt;
  logic                   busy_r, busy_nxt;
  logic                   fin_valid_r, fin_valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   accept;
  logic                   chain_done;
  logic                   move;
  logic                   wb_en;
  logic                   cfg_wr;
  kind_t                  in_kind_e;

  logic                    fin_found_r;
  logic [IDX_FIELD_W-1:0]  fin_idx_r;
  logic [SIZE_FIELD_W-1:0] fin_free_r;
  logic [SIZE_FIELD_W-1:0] fin_cap_r;
  logic [OWNER_W-1:0]      fin_owner_r;
  logic                    fin_alloc_r;

  logic                    out_found_r;
  logic [IDX_FIELD_W-1:0]  out_idx_r;
  logic [SIZE_FIELD_W-1:0] out_free_r;
  logic [SIZE_FIELD_W-1:0] out_cap_r;
  logic [OWNER_W-1:0]      out_owner_r;
  logic                    out_alloc_r;

  assign in_kind_e  = kind_t'(in_kind);
  assign accept     = in_valid && in_ready;
  assign in_ready   = !busy_r;
  assign chain_done = ctl_w[MAX_PARTITIONS].valid;
  assign move       = fin_valid_r && (!out_valid_r || out_ready);
  assign wb_en      = chain_done && (ctl_w[MAX_PARTITIONS].kind == KIND_ALLOC) &&
                      found_w[MAX_PARTITIONS];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_ACTIVE);
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE) ? DATA_W'(act_r) : '0;

  always_comb begin
    act_nxt = act_r;
    if (cfg_wr) begin
      act_nxt = cfg_pwdata[ACTIVE_W-1:0];
    end
  end

  always_comb begin
    if (act_r == '0) begin
      cnt = CNT_W'(1);
    end else if (32'(act_r) > 32'(MAX_PARTITIONS)) begin
      cnt = CNT_W'(MAX_PARTITIONS);
    end else begin
      cnt = CNT_W'(act_r);
    end
  end

  always_comb begin
    ctl_w[0].valid = accept;
    ctl_w[0].kind  = in_kind_e;
    idx_w[0]       = in_partition_index;
    size_w[0]      = SIZE_BITS'(in_size_value);
    tag_w[0]       = in_owner_tag;
    found_w[0]     = 1'b0;
    best_w[0]      = '0;
    res_idx_w[0]   = ((in_kind_e == KIND_LOAD) || (in_kind_e == KIND_READ)) ?
                     in_partition_index : '0;
    res_free_w[0]  = '0;
    res_cap_w[0]   = '0;
    res_owner_w[0] = '0;
    res_alloc_w[0] = 1'b0;
  end

  for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
    bfpa_cell #(
      .CELL_ID (g),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W),
      .SIZE_W  (SIZE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cnt_i       (cnt),
      .wb_en_i     (wb_en),
      .wb_idx_i    (best_w[MAX_PARTITIONS]),
      .wb_free_i   (res_free_w[MAX_PARTITIONS]),
      .wb_owner_i  (res_owner_w[MAX_PARTITIONS]),
      .ctl_i       (ctl_w[g]),
      .idx_i       (idx_w[g]),
      .size_i      (size_w[g]),
      .tag_i       (tag_w[g]),
      .found_i     (found_w[g]),
      .best_i      (best_w[g]),
      .res_idx_i   (res_idx_w[g]),
      .res_free_i  (res_free_w[g]),
      .res_cap_i   (res_cap_w[g]),
      .res_owner_i (res_owner_w[g]),
      .res_alloc_i (res_alloc_w[g]),
      .ctl_o       (ctl_w[g+1]),
      .idx_o       (idx_w[g+1]),
      .size_o      (size_w[g+1]),
      .tag_o       (tag_w[g+1]),
      .found_o     (found_w[g+1]),
      .best_o      (best_w[g+1]),
      .res_idx_o   (res_idx_w[g+1]),
      .res_free_o  (res_free_w[g+1]),
      .res_cap_o   (res_cap_w[g+1]),
      .res_owner_o (res_owner_w[g+1]),
      .res_alloc_o (res_alloc_w[g+1])
    );
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (move) begin
      busy_nxt = 1'b0;
    end
    fin_valid_nxt = chain_done || (fin_valid_r && !move);
    out_valid_nxt = move || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= ACTIVE_RESET;
      busy_r      <= 1'b0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      busy_r      <= busy_nxt;
      fin_valid_r <= fin_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_done) begin
      fin_found_r <= found_w[MAX_PARTITIONS];
      fin_idx_r   <= res_idx_w[MAX_PARTITIONS];
      fin_free_r  <= SIZE_FIELD_W'(res_free_w[MAX_PARTITIONS]);
      fin_cap_r   <= SIZE_FIELD_W'(res_cap_w[MAX_PARTITIONS]);
      fin_owner_r <= res_owner_w[MAX_PARTITIONS];
      fin_alloc_r <= res_alloc_w[MAX_PARTITIONS];
    end
    if (move) begin
      out_found_r <= fin_found_r;
      out_idx_r   <= fin_idx_r;
      out_free_r  <= fin_free_r;
      out_cap_r   <= fin_cap_r;
      out_owner_r <= fin_owner_r;
      out_alloc_r <= fin_alloc_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fit_found    = out_found_r;
  assign out_chosen_index = out_idx_r;
  assign out_free_left    = out_free_r;
  assign out_capacity_out = out_cap_r;
  assign out_owner_out    = out_owner_r;
  assign out_is_allocated = out_alloc_r;

endmodule

// File: rtl/bfpa_checker.sv
module bfpa_checker
  import bfpa_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_fit_found,
  input logic [IDX_FIELD_W-1:0]  out_chosen_index,
  input logic [SIZE_FIELD_W-1:0] out_free_left,
  input logic [SIZE_FIELD_W-1:0] out_capacity_out,
  input logic [OWNER_W-1:0]      out_owner_out,
  input logic                    out_is_allocated
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_fit_found) &&
      $stable(out_chosen_index) && $stable(out_free_left) &&
      $stable(out_capacity_out) && $stable(out_owner_out) &&
      $stable(out_is_allocated)))
    else $error("stalled result changed");

endmodule

bind best_fit_partition_allocator bfpa_checker u_bfpa_checker (.*);
